[hdl/scdt_pkg.sv]
`default_nettype none

package scdt_pkg;

  // Row numbers arrive on a fixed 10-bit field, so the row store never
  // needs more than this many entries.
  localparam int ROW_W    = 10;
  localparam int ROW_SPAN = 1 << ROW_W;

  // Commands carried by an input item.
  localparam logic [2:0] CMD_BEGIN_FIRST  = 3'd0;
  localparam logic [2:0] CMD_FIRST_ENTRY  = 3'd1;
  localparam logic [2:0] CMD_BEGIN_SECOND = 3'd2;
  localparam logic [2:0] CMD_SECOND_ENTRY = 3'd3;
  localparam logic [2:0] CMD_FINISH       = 3'd4;

  // Dominance direction: LESS means the first column is the cheaper one.
  localparam logic [1:0] DIR_UNDECIDED = 2'd0;
  localparam logic [1:0] DIR_LESS      = 2'd1;
  localparam logic [1:0] DIR_GREATER   = 2'd2;

  // Verdict codes.
  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_FIRST  = 2'd1;
  localparam logic [1:0] OUT_SECOND = 2'd2;

  localparam logic signed [16:0] ID_NONE = -17'sd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // input item accepted this cycle
    logic sweep_wr;     // zero one row entry during the power-up sweep
    logic idx_clr;      // restart the walk index
    logic idx_inc;      // read the row list at the index and advance
    logic walk_wr;      // write the row named by the list read data
    logic walk_set;     // mark value for a walk write; 0 also zeroes the coefficient
    logic row_rd_list;  // read the row store at the list read data
    logic test_chk;     // test a listed row against zero
    logic test_entry;   // test a second-column entry
    logic entry_wr;     // store a first-column entry
    logic count_clr;    // empty the first-column list
    logic emit;         // load the result register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       idx_end;
    logic       sweep_last;
    logic       chk_needed;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

[hdl/scdt_ctrl.sv]
`default_nettype none

module scdt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire scdt_pkg::sts_t sts,
  output scdt_pkg::ctl_t     ctl
);

  localparam logic [3:0] S_SWEEP   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ENTRY   = 4'd2;
  localparam logic [3:0] S_TEST    = 4'd3;
  localparam logic [3:0] S_CLEAR   = 4'd4;
  localparam logic [3:0] S_REMARK  = 4'd5;
  localparam logic [3:0] S_CHECK   = 4'd6;
  localparam logic [3:0] S_FREMARK = 4'd7;
  localparam logic [3:0] S_EMIT    = 4'd8;

  logic [3:0] state, state_next;
  // Pipeline occupancy of the list walks: p1 marks valid list read data,
  // p2 marks valid row read data.
  logic p1, p1_next;
  logic p2, p2_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    p1_next    = 1'b0;
    p2_next    = 1'b0;
    case (state)
      S_SWEEP: begin
        ctl.sweep_wr = 1'b1;
        ctl.idx_inc  = 1'b1;
        if (sts.sweep_last) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.take    = 1'b1;
          ctl.idx_clr = 1'b1;
          case (sts.cmd)
            scdt_pkg::CMD_BEGIN_FIRST:  state_next = S_CLEAR;
            scdt_pkg::CMD_FIRST_ENTRY:  state_next = S_ENTRY;
            scdt_pkg::CMD_BEGIN_SECOND: state_next = S_REMARK;
            scdt_pkg::CMD_SECOND_ENTRY: state_next = S_TEST;
            scdt_pkg::CMD_FINISH:       state_next = sts.chk_needed ? S_CHECK : S_FREMARK;
            default:                    state_next = S_IDLE;
          endcase
        end
      end
      S_ENTRY: begin
        ctl.entry_wr = 1'b1;
        state_next   = S_IDLE;
      end
      S_TEST: begin
        ctl.test_entry = 1'b1;
        state_next     = S_IDLE;
      end
      S_CLEAR, S_REMARK, S_FREMARK: begin
        ctl.idx_inc  = !sts.idx_end;
        ctl.walk_wr  = p1;
        ctl.walk_set = (state != S_CLEAR);
        p1_next      = !sts.idx_end;
        if (sts.idx_end) begin
          case (state)
            S_CLEAR: begin
              ctl.count_clr = 1'b1;
              state_next    = S_IDLE;
            end
            S_REMARK: state_next = S_IDLE;
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_CHECK: begin
        ctl.idx_inc     = !sts.idx_end;
        ctl.row_rd_list = p1;
        ctl.test_chk    = p2;
        p1_next         = !sts.idx_end;
        p2_next         = p1;
        if (sts.idx_end && !p1) begin
          ctl.idx_clr = 1'b1;
          p1_next     = 1'b0;
          p2_next     = 1'b0;
          state_next  = S_FREMARK;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      p1    <= 1'b0;
      p2    <= 1'b0;
    end else begin
      state <= state_next;
      p1    <= p1_next;
      p2    <= p2_next;
    end
  end

endmodule

`default_nettype wire

[hdl/scdt_datapath.sv]
`default_nettype none

module scdt_datapath #(
  parameter int MAX_ROWS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scdt_pkg::ctl_t     ctl,
  output scdt_pkg::sts_t          sts,
  input  wire logic [2:0]         command,
  input  wire logic [15:0]        column_id,
  input  wire logic signed [31:0] cost,
  input  wire logic [9:0]         row,
  input  wire logic signed [31:0] coef,
  input  wire logic               row_is_equality,
  input  wire logic               row_inactive,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic signed [16:0]      dominant_id,
  output logic signed [16:0]      dominated_id,
  output logic [1:0]              outcome
);

  localparam int ROW_DEPTH = (MAX_ROWS < scdt_pkg::ROW_SPAN) ? MAX_ROWS : scdt_pkg::ROW_SPAN;
  localparam int ROW_AW    = $clog2(ROW_DEPTH);
  localparam int LIST_AW   = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);

  // Returns {pass, new direction}.
  function automatic logic [2:0] row_test(input logic [1:0] d,
                                          input logic signed [31:0] w,
                                          input logic signed [31:0] a,
                                          input logic eq);
    logic       pass;
    logic [1:0] nd;
    pass = 1'b1;
    nd   = d;
    if (eq) begin
      pass = (w == a);
    end else begin
      case (d)
        scdt_pkg::DIR_LESS:    pass = !(w > a);
        scdt_pkg::DIR_GREATER: pass = !(w < a);
        default: begin
          if (w < a) begin
            nd = scdt_pkg::DIR_LESS;
          end else if (w > a) begin
            nd = scdt_pkg::DIR_GREATER;
          end
        end
      endcase
    end
    return {pass, nd};
  endfunction

  // Row store: {equality flag, coefficient} and the mark bit, indexed by row.
  logic [32:0] cmem [ROW_DEPTH];
  logic        mmem [ROW_DEPTH];
  // First-column row list.
  logic [scdt_pkg::ROW_W-1:0] lmem [MAX_ROWS];

  logic [scdt_pkg::ROW_W-1:0] cap_row;
  logic signed [31:0]         cap_coef;
  logic                       cap_eq;
  logic                       cap_skip;

  logic [15:0]        first_id;
  logic [15:0]        second_id;
  logic signed [31:0] first_cost;
  logic [CNT_W-1:0]   first_count;
  logic [CNT_W-1:0]   remaining;
  logic [1:0]         dir;
  logic               failed;
  logic [CNT_W-1:0]   idx;

  logic [scdt_pkg::ROW_W-1:0] list_q;
  logic signed [31:0]         coef_q;
  logic                       eq_q;
  logic                       mark_q;

  logic               row_ok;
  logic               entry_ok;
  logic               tst_en;
  logic               tst_pass;
  logic [1:0]         tst_dir;
  logic [2:0]         tst_res;
  logic signed [31:0] tst_a;
  logic               tst_eq;
  logic               clr_mark;

  logic [ROW_AW-1:0] cw_addr;
  logic              cw_en;
  logic [32:0]       cw_data;
  logic              mw_en;
  logic              mw_data;
  logic [ROW_AW-1:0] rd_addr;
  logic              rd_en;

  assign row_ok   = 32'(row) < 32'(MAX_ROWS);
  assign entry_ok = !cap_skip && (first_count != CNT_W'(MAX_ROWS));

  assign tst_a    = ctl.test_chk ? 32'sd0 : cap_coef;
  assign tst_eq   = ctl.test_chk ? eq_q : cap_eq;
  assign tst_res  = row_test(dir, coef_q, tst_a, tst_eq);
  assign tst_pass = tst_res[2];
  assign tst_dir  = tst_res[1:0];
  assign tst_en   = !failed && ((ctl.test_entry && !cap_skip) || (ctl.test_chk && mark_q));
  assign clr_mark = ctl.test_entry && tst_en && tst_pass && mark_q;

  assign cw_addr = ctl.sweep_wr ? idx[ROW_AW-1:0] :
                   ctl.walk_wr  ? list_q[ROW_AW-1:0] : cap_row[ROW_AW-1:0];
  assign cw_en   = ctl.sweep_wr || (ctl.walk_wr && !ctl.walk_set) ||
                   (ctl.entry_wr && entry_ok);
  assign cw_data = ctl.entry_wr ? {cap_eq, cap_coef} : 33'd0;
  assign mw_en   = ctl.sweep_wr || ctl.walk_wr || (ctl.entry_wr && entry_ok) || clr_mark;
  assign mw_data = ctl.walk_wr ? ctl.walk_set : ctl.entry_wr;
  assign rd_addr = ctl.take ? row[ROW_AW-1:0] : list_q[ROW_AW-1:0];
  assign rd_en   = ctl.take || ctl.row_rd_list;

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cmem[cw_addr] <= cw_data;
    end
    if (rd_en) begin
      coef_q <= cmem[rd_addr][31:0];
      eq_q   <= cmem[rd_addr][32];
    end
  end

  always_ff @(posedge clk) begin
    if (mw_en) begin
      mmem[cw_addr] <= mw_data;
    end
    if (rd_en) begin
      mark_q <= mmem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.entry_wr && entry_ok) begin
      lmem[first_count[LIST_AW-1:0]] <= cap_row;
    end
    if (ctl.idx_inc) begin
      list_q <= lmem[idx[LIST_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cap_row  <= row;
      cap_coef <= coef;
      cap_eq   <= row_is_equality;
      cap_skip <= row_inactive || !row_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_id    <= '0;
      second_id   <= '0;
      first_cost  <= '0;
      first_count <= '0;
      remaining   <= '0;
      dir         <= scdt_pkg::DIR_UNDECIDED;
      failed      <= 1'b0;
      idx         <= '0;
    end else begin
      if (ctl.take) begin
        case (command)
          scdt_pkg::CMD_BEGIN_FIRST: begin
            first_id   <= column_id;
            first_cost <= cost;
            failed     <= 1'b0;
            remaining  <= '0;
          end
          scdt_pkg::CMD_BEGIN_SECOND: begin
            second_id <= column_id;
            failed    <= 1'b0;
            remaining <= first_count;
            if (first_cost < cost) begin
              dir <= scdt_pkg::DIR_LESS;
            end else if (first_cost > cost) begin
              dir <= scdt_pkg::DIR_GREATER;
            end else begin
              dir <= scdt_pkg::DIR_UNDECIDED;
            end
          end
          default: ;
        endcase
      end else if (tst_en) begin
        if (!tst_pass) begin
          failed <= 1'b1;
        end else begin
          dir <= tst_dir;
        end
      end

      if (clr_mark && (remaining != '0)) begin
        remaining <= remaining - 1'b1;
      end

      if (ctl.count_clr) begin
        first_count <= '0;
      end else if (ctl.entry_wr && entry_ok) begin
        first_count <= first_count + 1'b1;
      end

      if (ctl.idx_clr) begin
        idx <= '0;
      end else if (ctl.idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      if (!failed && (dir == scdt_pkg::DIR_LESS)) begin
        dominant_id  <= $signed({1'b0, first_id});
        dominated_id <= $signed({1'b0, second_id});
        outcome      <= scdt_pkg::OUT_FIRST;
      end else if (!failed && (dir == scdt_pkg::DIR_GREATER)) begin
        dominant_id  <= $signed({1'b0, second_id});
        dominated_id <= $signed({1'b0, first_id});
        outcome      <= scdt_pkg::OUT_SECOND;
      end else begin
        dominant_id  <= scdt_pkg::ID_NONE;
        dominated_id <= scdt_pkg::ID_NONE;
        outcome      <= scdt_pkg::OUT_NONE;
      end
    end
  end

  assign sts.cmd        = command;
  assign sts.idx_end    = (idx == first_count);
  assign sts.sweep_last = (idx == CNT_W'(ROW_DEPTH - 1));
  assign sts.chk_needed = !failed && (remaining != '0);
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

[hdl/sparse_column_dominance_test.sv]
`default_nettype none

// Channel  Direction  Handshake             Item contents
// in       input      in_valid / in_stall   command, column_id, cost, row, coef,
//                                           row_is_equality, row_inactive
// out      output     out_valid / out_stall dominant_id, dominated_id, outcome
//
// An entry of either column reads the row store when it is taken and
// writes it back in the next state. A begin command walks the first-column
// row list; finish walks it twice through the single list read port when
// listed rows are left to check against zero, and once otherwise.
// After reset the row store is swept to zero, one row per cycle, over
// min(MAX_ROWS, 1024) rows, while in_stall stays high.
// The result register holds one item; finish waits only if it is still full
// and stalled, and every other command goes on while a result waits.

module sparse_column_dominance_test #(
  parameter int MAX_ROWS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         command,
  input  wire logic [15:0]        column_id,
  input  wire logic signed [31:0] cost,
  input  wire logic [9:0]         row,
  input  wire logic signed [31:0] coef,
  input  wire logic               row_is_equality,
  input  wire logic               row_inactive,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [16:0]      dominant_id,
  output logic signed [16:0]      dominated_id,
  output logic [1:0]              outcome
);

  // The controller sequences the list walks and the read-modify-write of
  // each entry; the datapath holds the row store, the row list, the column
  // registers, the row test and the result register.
  scdt_pkg::ctl_t ctl;
  scdt_pkg::sts_t sts;

  scdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  scdt_datapath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .command         (command),
    .column_id       (column_id),
    .cost            (cost),
    .row             (row),
    .coef            (coef),
    .row_is_equality (row_is_equality),
    .row_inactive    (row_inactive),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .dominant_id     (dominant_id),
    .dominated_id    (dominated_id),
    .outcome         (outcome)
  );

endmodule

`default_nettype wire

[tb/sparse_column_dominance_test_tb.sv]
`default_nettype none

module sparse_column_dominance_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with its full row store; a 10-bit row can never
  // fall outside it.
  localparam int ROWS             = 1024;
  // Input items with a defined command over the whole run, directed part included.
  localparam int TOTAL_ITEMS      = 1550;
  // A first column longer than the store: the tail must be dropped.
  localparam int OVERFLOW_ENTRIES = ROWS + 6;
  // The limit must cover a finish on a full first column, which can walk the
  // row list twice without a handshake, plus the post-reset sweep and the
  // longest receiver stall, and leaves a wide margin over all that.
  localparam int IDLE_LIMIT       = 20000;
  localparam int DRAIN_CYCLES     = 2 * ROWS + 16;
  localparam int REPORT_LIMIT     = 10;

  // Command codes outside the defined set; the block must ignore them.
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam longint WIDE_MAX = 64'sd2147483647;
  localparam longint WIDE_MIN = -64'sd2147483648;

  typedef struct {
    logic [2:0]         command;
    logic [15:0]        column_id;
    logic signed [31:0] cost;
    logic [9:0]         row;
    logic signed [31:0] coef;
    logic               row_is_equality;
    logic               row_inactive;
  } scd_item_t;

  typedef struct {
    logic signed [16:0] dominant_id;
    logic signed [16:0] dominated_id;
    logic [1:0]         outcome;
  } verdict_t;

  // Keeps a private copy of the row store and the comparison state, works
  // out the verdict that every finish must produce and checks the verdicts
  // that come out of the block in order.
  class verdict_board;
    verdict_t           expected_verdicts[$];
    int                 errors;

    logic signed [31:0] coefs[ROWS];
    bit                 marks[ROWS];
    bit                 eq_rows[ROWS];
    logic [9:0]         listed_rows[ROWS];
    int unsigned        list_len;
    int unsigned        open_marks;
    logic [1:0]         dir;
    bit                 failed;
    logic [15:0]        first_id;
    logic [15:0]        second_id;
    logic signed [31:0] first_cost;

    function new();
      for (int i = 0; i < ROWS; i++) begin
        coefs[i] = '0;
        marks[i] = 1'b0;
        eq_rows[i] = 1'b0;
        listed_rows[i] = '0;
      end
      list_len = 0;
      open_marks = 0;
      dir = scdt_pkg::DIR_UNDECIDED;
      failed = 1'b0;
      first_id = '0;
      second_id = '0;
      first_cost = '0;
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Tests stored coefficient w against a on one row and may settle an
    // undecided direction on the first strict difference.
    function bit row_fits(logic signed [31:0] w, logic signed [31:0] a, bit equality);
      if (equality) return w == a;
      if (dir == scdt_pkg::DIR_LESS) return !(w > a);
      if (dir == scdt_pkg::DIR_GREATER) return !(w < a);
      if (w < a) dir = scdt_pkg::DIR_LESS;
      else if (w > a) dir = scdt_pkg::DIR_GREATER;
      return 1'b1;
    endfunction

    function void remark_listed();
      for (int unsigned i = 0; i < list_len; i++) marks[listed_rows[i]] = 1'b1;
    endfunction

    function void note_item(scd_item_t it);
      verdict_t           v;
      logic [9:0]         r;
      logic signed [31:0] w;
      logic signed [31:0] a;
      int unsigned        i;
      case (it.command)
        scdt_pkg::CMD_BEGIN_FIRST: begin
          for (i = 0; i < list_len; i++) begin
            coefs[listed_rows[i]] = '0;
            marks[listed_rows[i]] = 1'b0;
          end
          list_len = 0;
          open_marks = 0;
          failed = 1'b0;
          first_id = it.column_id;
          first_cost = it.cost;
        end
        scdt_pkg::CMD_FIRST_ENTRY: begin
          if (!it.row_inactive && list_len < ROWS) begin
            coefs[it.row] = it.coef;
            eq_rows[it.row] = it.row_is_equality;
            marks[it.row] = 1'b1;
            listed_rows[list_len] = it.row;
            list_len++;
          end
        end
        scdt_pkg::CMD_BEGIN_SECOND: begin
          remark_listed();
          second_id = it.column_id;
          failed = 1'b0;
          open_marks = list_len;
          a = it.cost;
          if (first_cost < a) dir = scdt_pkg::DIR_LESS;
          else if (first_cost > a) dir = scdt_pkg::DIR_GREATER;
          else dir = scdt_pkg::DIR_UNDECIDED;
        end
        scdt_pkg::CMD_SECOND_ENTRY: begin
          if (!it.row_inactive && !failed) begin
            r = it.row;
            w = coefs[r];
            a = it.coef;
            if (!row_fits(w, a, it.row_is_equality)) begin
              failed = 1'b1;
            end else if (marks[r]) begin
              marks[r] = 1'b0;
              if (open_marks > 0) open_marks--;
            end
          end
        end
        scdt_pkg::CMD_FINISH: begin
          v.dominant_id = scdt_pkg::ID_NONE;
          v.dominated_id = scdt_pkg::ID_NONE;
          v.outcome = scdt_pkg::OUT_NONE;
          // Rows of the first column that the second one never touched
          // are compared against a zero coefficient.
          if (!failed && open_marks != 0) begin
            for (i = 0; i < list_len && !failed; i++) begin
              r = listed_rows[i];
              if (marks[r]) begin
                if (!row_fits(coefs[r], 32'sd0, eq_rows[r])) failed = 1'b1;
              end
            end
          end
          if (!failed) begin
            if (dir == scdt_pkg::DIR_LESS) begin
              v.dominant_id = {1'b0, first_id};
              v.dominated_id = {1'b0, second_id};
              v.outcome = scdt_pkg::OUT_FIRST;
            end else if (dir == scdt_pkg::DIR_GREATER) begin
              v.dominant_id = {1'b0, second_id};
              v.dominated_id = {1'b0, first_id};
              v.outcome = scdt_pkg::OUT_SECOND;
            end
          end
          remark_listed();
          expected_verdicts.push_back(v);
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        flag($sformatf("unexpected verdict: dominant %0d dominated %0d outcome %0d",
                       got.dominant_id, got.dominated_id, got.outcome));
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.dominant_id !== want.dominant_id)
        flag($sformatf("dominant_id mismatch: expected %0d got %0d",
                       want.dominant_id, got.dominant_id));
      if (got.dominated_id !== want.dominated_id)
        flag($sformatf("dominated_id mismatch: expected %0d got %0d",
                       want.dominated_id, got.dominated_id));
      if (got.outcome !== want.outcome)
        flag($sformatf("outcome mismatch: expected %0d got %0d", want.outcome, got.outcome));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         command = scdt_pkg::CMD_BEGIN_FIRST;
  logic [15:0]        column_id = '0;
  logic signed [31:0] cost = '0;
  logic [9:0]         row = '0;
  logic signed [31:0] coef = '0;
  logic               row_is_equality = 1'b0;
  logic               row_inactive = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] dominant_id;
  logic signed [16:0] dominated_id;
  logic [1:0]         outcome;

  sparse_column_dominance_test #(
    .MAX_ROWS(ROWS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .column_id(column_id),
    .cost(cost),
    .row(row),
    .coef(coef),
    .row_is_equality(row_is_equality),
    .row_inactive(row_inactive),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dominant_id(dominant_id),
    .dominated_id(dominated_id),
    .outcome(outcome)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  verdict_board board;
  verdict_t     seen_verdict;
  int           items_sent = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;
  int           stall_mode = 0;
  int           stall_timer = 0;
  logic [7:0]   stall_pattern = 8'b1100_1010;

  // What the stimulus knows of the current first column: the active rows
  // it has sent, their coefficients and equality flags, and its cost.
  // Second columns are built from this so that most of them get far
  // enough to reach a verdict.
  logic [9:0]         col_rows[$];
  logic signed [31:0] col_coefs[$];
  bit                 col_eq[$];
  logic signed [31:0] col_cost = '0;

  // Offers one item at the current falling edge and holds it until the
  // block takes it. The sender works in bursts: after a burst the valid
  // line drops and a new burst length is drawn. Some bursts are long, so
  // that back-to-back items also occur.
  task automatic send_item(input scd_item_t it);
    command = it.command;
    column_id = it.column_id;
    cost = it.cost;
    row = it.row;
    coef = it.coef;
    row_is_equality = it.row_is_equality;
    row_inactive = it.row_inactive;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    if (it.command <= scdt_pkg::CMD_FINISH) items_sent++;
    if (it.command == scdt_pkg::CMD_BEGIN_FIRST) begin
      col_rows.delete();
      col_coefs.delete();
      col_eq.delete();
      col_cost = it.cost;
    end else if (it.command == scdt_pkg::CMD_FIRST_ENTRY && !it.row_inactive &&
                 col_rows.size() < ROWS) begin
      col_rows.push_back(it.row);
      col_coefs.push_back(it.coef);
      col_eq.push_back(it.row_is_equality);
    end
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic issue(input logic [2:0] cmd, input logic [15:0] id,
                       input logic signed [31:0] cst, input logic [9:0] r,
                       input logic signed [31:0] cf, input logic eq, input logic inact);
    scd_item_t it;
    it.command = cmd;
    it.column_id = id;
    it.cost = cst;
    it.row = r;
    it.coef = cf;
    it.row_is_equality = eq;
    it.row_inactive = inact;
    send_item(it);
  endtask

  // Q16.16 values weighted toward zero, the two extremes and small whole
  // numbers, with plain random words for the rest.
  function automatic logic signed [31:0] pick_value();
    int k;
    k = int'($urandom_range(0, 32)) - 16;
    case ($urandom_range(0, 7))
      0: return 32'sd0;
      1: return Q_MAX;
      2: return Q_MIN;
      3: return k * 65536;
      default: return $urandom();
    endcase
  endfunction

  // Rows repeat now and then, so the same row is listed twice.
  function automatic logic [9:0] pick_row();
    if (col_rows.size() != 0 && $urandom_range(0, 3) == 0)
      return col_rows[$urandom_range(0, col_rows.size() - 1)];
    return 10'($urandom_range(0, ROWS - 1));
  endfunction

  // Moves w by a positive step in the direction of lean, clamped to the
  // Q16.16 range.
  function automatic logic signed [31:0] nudge(logic signed [31:0] w, int lean);
    longint v;
    longint step;
    if ($urandom_range(0, 2) != 0) step = longint'($urandom_range(1, 16'hFFFF));
    else step = longint'($urandom_range(1, 64)) * 65536;
    v = longint'(w) + lean * step;
    if (v > WIDE_MAX) v = WIDE_MAX;
    if (v < WIDE_MIN) v = WIDE_MIN;
    return v[31:0];
  endfunction

  // One round of the random part. Most rounds are a full comparison: a
  // fresh first column (or the previous one kept), a second column whose
  // coefficients lean the way its cost points, and a finish. The lean is
  // broken now and then, rows are skipped or added, flags are flipped, so
  // that failures show up at every stage. The remaining rounds are noise
  // with any command code and any field values.
  task automatic random_sequence();
    int                 mode;
    int                 n;
    int                 lean;
    int                 idx;
    int                 nudge_lo;
    logic signed [31:0] cost2;
    logic signed [31:0] a;
    bit                 eq;
    mode = $urandom_range(0, 99);
    if (mode >= 85) begin
      repeat ($urandom_range(1, 6))
        issue(3'($urandom_range(0, 7)), 16'($urandom), $urandom, 10'($urandom),
              pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      return;
    end
    if (mode < 70 || col_rows.size() == 0) begin
      issue(scdt_pkg::CMD_BEGIN_FIRST, 16'($urandom), pick_value(), 10'($urandom),
            $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 40);
      repeat (n)
        issue(scdt_pkg::CMD_FIRST_ENTRY, 16'($urandom), $urandom, pick_row(), pick_value(),
              $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
    end
    // A finish before the second column has begun.
    if ($urandom_range(0, 19) == 0)
      issue(scdt_pkg::CMD_FINISH, 16'($urandom), $urandom, 10'($urandom), $urandom,
            1'b0, 1'b0);
    nudge_lo = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 2))
      0: cost2 = col_cost;
      1: cost2 = pick_value();
      default: cost2 = col_cost + nudge_lo;
    endcase
    if (col_cost < cost2) lean = 1;
    else if (col_cost > cost2) lean = -1;
    else lean = $urandom_range(0, 1) ? 1 : -1;
    issue(scdt_pkg::CMD_BEGIN_SECOND, 16'($urandom), cost2, 10'($urandom), $urandom,
          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (idx = 0; idx < col_rows.size(); idx++) begin
      if ($urandom_range(0, 5) != 0) begin
        eq = col_eq[idx];
        if ($urandom_range(0, 9) == 0) eq = !eq;
        if ($urandom_range(0, 11) == 0) lean = -lean;
        a = (eq || $urandom_range(0, 2) == 0) ? col_coefs[idx] : nudge(col_coefs[idx], lean);
        issue(scdt_pkg::CMD_SECOND_ENTRY, 16'($urandom), $urandom, col_rows[idx], a, eq,
              $urandom_range(0, 9) == 0);
      end
      // A random row is added; one that the first column does not have compares against zero.
      if ($urandom_range(0, 4) == 0)
        issue(scdt_pkg::CMD_SECOND_ENTRY, 16'($urandom), $urandom,
              10'($urandom_range(0, ROWS - 1)),
              $urandom_range(0, 1) ? 32'sd0 : nudge(32'sd0, lean),
              $urandom_range(0, 5) == 0, 1'b0);
    end
    issue(scdt_pkg::CMD_FINISH, 16'($urandom), $urandom, 10'($urandom), $urandom,
          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 7) == 0)
      issue(scdt_pkg::CMD_FINISH, 16'($urandom), $urandom, 10'($urandom), $urandom,
            1'b0, 1'b0);
  endtask

  // The receiver switches at random among four stall behaviors: never
  // stalling, stalling now and then, stalling most of the time, or
  // following a fixed bit pattern.
  always @(negedge clk) begin
    if (stall_timer == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_timer = $urandom_range(32, 256);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      2: out_stall = ($urandom_range(0, 3) != 0);
      default: out_stall = stall_pattern[stall_timer[2:0]];
    endcase
  end

  // Every verdict taken from the block goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_verdict.dominant_id = dominant_id;
      seen_verdict.dominated_id = dominated_id;
      seen_verdict.outcome = outcome;
      board.check_verdict(seen_verdict);
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int idx;
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A finish with nothing loaded yields no dominance.
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);

    // First column at the extremes: lowest id and cost, the first and last
    // rows with the largest and smallest coefficients, and an inactive
    // entry that must leave no trace. The unused command codes go in
    // between and must be ignored.
    issue(scdt_pkg::CMD_BEGIN_FIRST, 16'h0000, Q_MIN, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FIRST_ENTRY, 16'h0000, 32'sd0, 10'd0, Q_MAX, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FIRST_ENTRY, 16'h0000, 32'sd0, 10'd1023, Q_MIN, 1'b1, 1'b0);
    issue(scdt_pkg::CMD_FIRST_ENTRY, 16'h0000, 32'sd0, 10'd5, Q_ONE, 1'b0, 1'b1);
    issue(CMD_SPARE_A, 16'hFFFF, Q_MAX, 10'd1023, Q_MAX, 1'b1, 1'b1);
    issue(CMD_SPARE_B, 16'hFFFF, Q_MAX, 10'd1023, Q_MAX, 1'b1, 1'b0);
    issue(CMD_SPARE_C, 16'hFFFF, Q_MIN, 10'd0, Q_MIN, 1'b0, 1'b1);

    // The second column costs more, so the first may dominate; equal
    // coefficients on both rows keep that. A repeated finish must give the
    // same verdict since the marks were restored.
    issue(scdt_pkg::CMD_BEGIN_SECOND, 16'hFFFF, Q_MAX, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_SECOND_ENTRY, 16'h0000, 32'sd0, 10'd0, Q_MAX, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_SECOND_ENTRY, 16'h0000, 32'sd0, 10'd1023, Q_MIN, 1'b1, 1'b0);
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);

    // Equal costs leave the direction open until the first strict
    // difference fixes it; the untouched equality row then fails its
    // check against zero.
    issue(scdt_pkg::CMD_BEGIN_SECOND, 16'h00FF, Q_MIN, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_SECOND_ENTRY, 16'h0000, 32'sd0, 10'd0, Q_MAX - 1, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);

    // A row given twice keeps the last coefficient and is listed twice. A
    // finish before the second column keeps the old direction.
    issue(scdt_pkg::CMD_BEGIN_FIRST, 16'h1234, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FIRST_ENTRY, 16'h0000, 32'sd0, 10'h2AA, Q_ONE, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FIRST_ENTRY, 16'h0000, 32'sd0, 10'h2AA, -Q_ONE, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_BEGIN_SECOND, 16'h5555, 32'sd1, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_SECOND_ENTRY, 16'h0000, 32'sd0, 10'h155, 32'sd5, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);

    // A cheaper second column fails on its first entry; the entry after
    // the failure must be ignored.
    issue(scdt_pkg::CMD_BEGIN_SECOND, 16'hAAAA, -32'sd1, 10'd0, 32'sd0, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_SECOND_ENTRY, 16'h0000, 32'sd0, 10'h155, 32'sd1, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_SECOND_ENTRY, 16'h0000, 32'sd0, 10'h2AA, -Q_ONE, 1'b0, 1'b0);
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);

    // A first column with more active entries than the store holds; the
    // entries past the limit must be dropped.
    issue(scdt_pkg::CMD_BEGIN_FIRST, 16'($urandom), pick_value(), 10'd0, 32'sd0, 1'b0, 1'b0);
    repeat (OVERFLOW_ENTRIES)
      issue(scdt_pkg::CMD_FIRST_ENTRY, 16'($urandom), $urandom,
            10'($urandom_range(0, ROWS - 1)), pick_value(),
            $urandom_range(0, 3) == 0, 1'b0);
    issue(scdt_pkg::CMD_BEGIN_SECOND, 16'($urandom), col_cost, 10'd0, 32'sd0, 1'b0, 1'b0);
    for (idx = 0; idx < 8; idx++)
      issue(scdt_pkg::CMD_SECOND_ENTRY, 16'($urandom), $urandom, col_rows[idx],
            col_coefs[idx], col_eq[idx], 1'b0);
    issue(scdt_pkg::CMD_FINISH, 16'h0000, 32'sd0, 10'd0, 32'sd0, 1'b0, 1'b0);

    // Random rounds fill the run up to its item count.
    while (items_sent < TOTAL_ITEMS) random_sequence();
    in_valid = 1'b0;

    // Wait for every verdict, then let the block run on for as long as a
    // full finish could take, so that stray verdicts are caught too.
    while (board.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.expected_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
